### design/dfps_pkg.sv
// Shared types and constants for the deduplicating point store.
// No dependencies; imported by the front, queue, back and checker modules.
package dfps_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_SAVE   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_EVICTED   = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_NONFINITE = 3'd3;
  localparam logic [2:0] ST_READ_OK   = 3'd4;
  localparam logic [2:0] ST_RANGE     = 3'd5;
  localparam logic [2:0] ST_SAVED     = 3'd6;

  localparam int RAW_W   = 24;
  localparam int IDX_W   = 16;
  localparam int LIMIT_W = 17;
  localparam int LIMIT_RESET = 65536;

  // 2^35 / 10 rounded up; exact quotient for dividends below 2^32
  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

  // Classified request handed from the front to the back
  typedef struct packed {
    op_t                op;
    logic               finite;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [IDX_W-1:0]   index;
  } req_t;

endpackage

### design/dfps_front.sv
// Front end: accepts requests and rounds coordinates to millimetres.
// Depends on dfps_pkg; feeds dfps_queue.
module dfps_front
  import dfps_pkg::*;
#(
  parameter int COORD_BITS = 21
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              opcode,
  input  logic signed [RAW_W-1:0] coord_x,
  input  logic signed [RAW_W-1:0] coord_y,
  input  logic signed [RAW_W-1:0] coord_z,
  input  logic                    is_finite,
  input  logic [IDX_W-1:0]        read_index,
  output logic                    push_valid,
  input  logic                    push_ready,
  output req_t                    push_item
);

  logic             s1_valid;
  op_t              s1_op;
  logic             s1_finite;
  logic [IDX_W-1:0] s1_index;
  logic [2:0]       s1_neg;
  logic [56:0]      s1_prod [3];

  logic signed [RAW_W-1:0] raw [3];
  logic [24:0]             mag5 [3];
  logic [56:0]             prod [3];

  // Clamp a magnitude to the signed COORD_BITS range and apply the sign
  function automatic logic signed [31:0] round_sat(input logic neg, input logic [21:0] q);
    logic [32:0] hi;
    logic [32:0] lim;
    logic [32:0] m;
    logic [32:0] r;
    hi  = (33'd1 << (COORD_BITS - 1)) - 33'd1;
    lim = neg ? hi + 33'd1 : hi;
    m   = (33'(q) > lim) ? lim : 33'(q);
    r   = neg ? (33'd0 - m) : m;
    return r[31:0];
  endfunction

  assign raw[0] = coord_x;
  assign raw[1] = coord_y;
  assign raw[2] = coord_z;

  // Take |v| + 5 and multiply by the reciprocal of ten
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag5[k] = (raw[k][RAW_W-1] ? (25'd0 - 25'(raw[k])) : 25'(raw[k])) + 25'd5;
      prod[k] = 57'(mag5[k]) * 57'(RECIP10);
    end
  end

  assign in_ready = !s1_valid || push_ready;

  // Hold the product stage until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_op     <= op_t'(opcode);
      s1_finite <= is_finite;
      s1_index  <= read_index;
      for (int k = 0; k < 3; k++) begin
        s1_neg[k]  <= raw[k][RAW_W-1];
        s1_prod[k] <= prod[k];
      end
    end
  end

  assign push_valid       = s1_valid;
  assign push_item.op     = s1_op;
  assign push_item.finite = s1_finite;
  assign push_item.index  = s1_index;
  assign push_item.x      = round_sat(s1_neg[0], s1_prod[0][56:35]);
  assign push_item.y      = round_sat(s1_neg[1], s1_prod[1][56:35]);
  assign push_item.z      = round_sat(s1_neg[2], s1_prod[2][56:35]);

endmodule

### design/dfps_queue.sv
// Two-entry request queue between front and back.
// Depends on dfps_pkg for the request type.
module dfps_queue
  import dfps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  req_t push_item,
  output logic pop_valid,
  input  logic pop_ready,
  output req_t pop_item
);

  req_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_item   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(do_push) - 2'(do_pop);
    end
    if (do_push) entry[wr_ptr] <= push_item;
  end

endmodule

### design/dfps_back.sv
// Back end: ring memory, duplicate scan, eviction, reads and result register.
// Depends on dfps_pkg; consumes requests from dfps_queue.
module dfps_back
  import dfps_pkg::*;
#(
  parameter int CAPACITY   = 65536,
  parameter int COORD_BITS = 21,
  parameter int SLOT_W     = $clog2(CAPACITY),
  parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [LIMIT_W-1:0]           point_limit,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  req_t                         pop_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   status,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic signed [COORD_BITS-1:0] point_z,
  output logic [CNT_W-1:0]             stored_count,
  output logic                         changed
);

  localparam int ENT_W = 3 * COORD_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EVICT, S_WRITE, S_RDWAIT, S_DONE
  } state_t;

  state_t            state;
  req_t              cur;
  logic [SLOT_W-1:0] oldest;
  logic [CNT_W-1:0]  held;
  logic              mark;
  logic [CNT_W-1:0]  scan_cnt;
  logic [SLOT_W-1:0] scan_slot;
  logic              pend;
  logic              evicted;
  logic [2:0]        res_status;
  logic [ENT_W-1:0]  res_point;

  logic [ENT_W-1:0]  mem [CAPACITY];
  logic [ENT_W-1:0]  rd_data;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [ENT_W-1:0]  cur_point;
  logic [CNT_W-1:0]  lim;
  logic [31:0]       lim32;
  logic              idx_ok;
  logic              out_free;

  // Ring slot of an age offset from a base slot
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (s >= (CNT_W + 1)'(CAPACITY)) s = s - (CNT_W + 1)'(CAPACITY);
    return s[SLOT_W-1:0];
  endfunction

  assign cur_point = {cur.x[COORD_BITS-1:0], cur.y[COORD_BITS-1:0], cur.z[COORD_BITS-1:0]};

  // Effective limit: zero acts as one, capped at capacity
  always_comb begin
    lim32 = 32'(point_limit);
    if (lim32 == 32'd0) lim32 = 32'd1;
    if (lim32 > 32'(CAPACITY)) lim32 = 32'(CAPACITY);
    lim = CNT_W'(lim32);
  end

  assign idx_ok    = 32'(pop_item.index) < 32'(held);
  assign pop_ready = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_slot;
    if (state == S_IDLE && pop_valid && pop_item.op == OP_READ) begin
      rd_en   = 1'b1;
      rd_addr = slot_add(oldest, CNT_W'(pop_item.index));
    end else if (state == S_SCAN && scan_cnt < held) begin
      rd_en = 1'b1;
    end
  end

  assign wr_en   = (state == S_WRITE);
  assign wr_addr = slot_add(oldest, held);

  // Ring storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= cur_point;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      oldest    <= '0;
      held      <= '0;
      mark      <= 1'b0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      // Drop a taken result unless a new one replaces it this cycle
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            cur        <= pop_item;
            res_point  <= '0;
            res_status <= ST_RANGE;
            state      <= S_DONE;
            unique case (pop_item.op)
              OP_INSERT: begin
                mark <= 1'b1;
                if (!pop_item.finite) begin
                  res_status <= ST_NONFINITE;
                end else begin
                  scan_cnt  <= '0;
                  scan_slot <= oldest;
                  pend      <= 1'b0;
                  state     <= S_SCAN;
                end
              end
              OP_READ: begin
                if (idx_ok) state <= S_RDWAIT;
              end
              OP_SAVE: begin
                mark       <= 1'b0;
                res_status <= ST_SAVED;
              end
              OP_NONE: begin
                res_status <= ST_RANGE;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Compare the entry fetched last cycle, issue the next read
          if (pend && rd_data == cur_point) begin
            res_status <= ST_DUPLICATE;
            res_point  <= cur_point;
            pend       <= 1'b0;
            state      <= S_DONE;
          end else if (scan_cnt == held && !pend) begin
            state <= S_EVICT;
          end else if (scan_cnt < held) begin
            pend      <= 1'b1;
            scan_cnt  <= scan_cnt + CNT_W'(1);
            scan_slot <= (scan_slot == SLOT_W'(CAPACITY - 1)) ? '0 : scan_slot + SLOT_W'(1);
          end else begin
            pend <= 1'b0;
          end
        end
        S_EVICT: begin
          // Drop as many oldest entries as the limit needs in one step
          if (held >= lim) begin
            oldest  <= slot_add(oldest, held - lim + CNT_W'(1));
            held    <= lim - CNT_W'(1);
            evicted <= 1'b1;
          end else begin
            evicted <= 1'b0;
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          held       <= held + CNT_W'(1);
          res_status <= evicted ? ST_EVICTED : ST_INSERTED;
          res_point  <= cur_point;
          state      <= S_DONE;
        end
        S_RDWAIT: begin
          res_status <= ST_READ_OK;
          res_point  <= rd_data;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            point_x      <= res_point[ENT_W-1 -: COORD_BITS];
            point_y      <= res_point[2*COORD_BITS-1 -: COORD_BITS];
            point_z      <= res_point[COORD_BITS-1:0];
            stored_count <= held;
            changed      <= mark;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/dedup_fifo_point_store.sv
// Deduplicating point store. Points come in at 0.1 mm and are rounded half away
// from zero to millimetres; non-finite points are dropped, and a point equal to
// one already held is reported as a duplicate. New points go into an age-ordered
// ring of CAPACITY entries, and the oldest entries are evicted to stay within
// point_limit. An insert first runs a duplicate scan, which reads the ring one
// entry per cycle through its single read port. The front rounds and queues up
// to three requests while the back works. Results wait in an output register.
// Depends on dfps_pkg, dfps_front, dfps_queue and dfps_back.
module dedup_fifo_point_store
  import dfps_pkg::*;
#(
  parameter int CAPACITY   = 65536,
  parameter int COORD_BITS = 21
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic [LIMIT_W-1:0]                    cfg_write_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            opcode,
  input  logic signed [RAW_W-1:0]               coord_x,
  input  logic signed [RAW_W-1:0]               coord_y,
  input  logic signed [RAW_W-1:0]               coord_z,
  input  logic                                  is_finite,
  input  logic [IDX_W-1:0]                      read_index,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0]                            status,
  output logic signed [COORD_BITS-1:0]          point_x,
  output logic signed [COORD_BITS-1:0]          point_y,
  output logic signed [COORD_BITS-1:0]          point_z,
  output logic [$clog2(CAPACITY + 1)-1:0]       stored_count,
  output logic                                  changed
);

  logic [LIMIT_W-1:0] point_limit;
  logic               push_valid;
  logic               push_ready;
  req_t               push_item;
  logic               pop_valid;
  logic               pop_ready;
  req_t               pop_item;

  // Hold the point limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      point_limit <= LIMIT_W'(LIMIT_RESET);
    end else if (cfg_write_en) begin
      point_limit <= cfg_write_data;
    end
  end

  dfps_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .opcode, .coord_x, .coord_y, .coord_z,
    .is_finite, .read_index, .push_valid, .push_ready, .push_item
  );

  dfps_queue u_queue (
    .clk, .rst, .push_valid, .push_ready, .push_item, .pop_valid, .pop_ready, .pop_item
  );

  dfps_back #(.CAPACITY(CAPACITY), .COORD_BITS(COORD_BITS)) u_back (
    .clk, .rst, .point_limit, .pop_valid, .pop_ready, .pop_item, .out_valid, .out_ready,
    .status, .point_x, .point_y, .point_z, .stored_count, .changed
  );

endmodule

### design/dfps_checker.sv
// Port-level checks on the result channel of the point store.
// Depends on dfps_pkg; bound to dedup_fifo_point_store below.
module dfps_checker
  import dfps_pkg::*;
#(
  parameter int CNT_W = 17
) (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       status,
  input logic [CNT_W-1:0] stored_count,
  input logic             changed
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(stored_count))
    else $error("result changed while stalled");

  // Every insert request leaves the changed mark set
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_INSERTED || status == ST_EVICTED ||
                  status == ST_DUPLICATE || status == ST_NONFINITE) |-> changed)
    else $error("insert without changed mark");

  // Saving clears the changed mark
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_SAVED |-> !changed)
    else $error("save left changed mark set");

  // Stored, duplicate and read-ok results need a non-empty store
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_INSERTED || status == ST_EVICTED ||
                  status == ST_DUPLICATE || status == ST_READ_OK) |-> stored_count != '0)
    else $error("point result with empty store");

endmodule

bind dedup_fifo_point_store dfps_checker #(.CNT_W($clog2(CAPACITY + 1))) u_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .status(status), .stored_count(stored_count), .changed(changed)
);
